// File: rtl/esd_pkg.sv
// Shared types, character codes and the hex digit helper function of the escape sequence decoder.
package esd_pkg;

    localparam int CHAR_W        = 16;
    localparam int CHAR_BITS_DEF = 16;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_HEX    = 2'd2
    } mode_t;

    localparam logic [CHAR_W-1:0] CH_BSLASH = 16'h005C;
    localparam logic [CHAR_W-1:0] CH_A      = 16'h0061;
    localparam logic [CHAR_W-1:0] CH_B      = 16'h0062;
    localparam logic [CHAR_W-1:0] CH_F      = 16'h0066;
    localparam logic [CHAR_W-1:0] CH_N      = 16'h006E;
    localparam logic [CHAR_W-1:0] CH_R      = 16'h0072;
    localparam logic [CHAR_W-1:0] CH_T      = 16'h0074;
    localparam logic [CHAR_W-1:0] CH_V      = 16'h0076;
    localparam logic [CHAR_W-1:0] CH_X      = 16'h0078;
    localparam logic [CHAR_W-1:0] CH_U      = 16'h0075;

    localparam logic [CHAR_W-1:0] CODE_BEL = 16'd7;
    localparam logic [CHAR_W-1:0] CODE_BS  = 16'd8;
    localparam logic [CHAR_W-1:0] CODE_FF  = 16'd12;
    localparam logic [CHAR_W-1:0] CODE_LF  = 16'd10;
    localparam logic [CHAR_W-1:0] CODE_CR  = 16'd13;
    localparam logic [CHAR_W-1:0] CODE_HT  = 16'd9;
    localparam logic [CHAR_W-1:0] CODE_VT  = 16'd11;

    localparam logic [2:0] DIGITS_SHORT = 3'd2;
    localparam logic [2:0] DIGITS_LONG  = 3'd4;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              has;
        logic              last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       res1;
        res_t       res0;
    } dec_t;

    // Returns the digit value in the low four bits and a valid flag in the top bit.
    function automatic logic [4:0] hex_digit(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        v = '0;
        if (c inside {[16'h0030:16'h0039]}) begin
            v = c - 16'h0030;
            return {1'b1, v[3:0]};
        end else if (c inside {[16'h0041:16'h0046]}) begin
            v = c - 16'h0037;
            return {1'b1, v[3:0]};
        end else if (c inside {[16'h0061:16'h0066]}) begin
            v = c - 16'h0057;
            return {1'b1, v[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

// File: rtl/esd_decode.sv
// Escape decoding logic with the decoder state registers.
module esd_decode #(
    parameter int CHAR_BITS = esd_pkg::CHAR_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      fire,
    input  logic [esd_pkg::CHAR_W-1:0] in_char,
    input  logic                      in_last,
    output esd_pkg::dec_t             dec
);

    localparam int VAL_BITS = (CHAR_BITS < esd_pkg::CHAR_W) ? CHAR_BITS : esd_pkg::CHAR_W;

    esd_pkg::mode_t        mode_reg, mode_next;
    logic [VAL_BITS-1:0]   hv_reg, hv_next;
    logic [2:0]            dt_reg, dt_next;
    logic                  long_reg, long_next;

    logic [esd_pkg::CHAR_W-1:0] c;
    logic [4:0]                 digit;
    logic [VAL_BITS-1:0]        hv_shift;
    logic [2:0]                 dt_inc;
    logic [2:0]                 dt_need;
    esd_pkg::res_t              res [2];
    logic [1:0]                 n;

    assign c        = esd_pkg::CHAR_W'(in_char[VAL_BITS-1:0]);
    assign digit    = esd_pkg::hex_digit(c);
    assign hv_shift = {hv_reg[VAL_BITS-5:0], digit[3:0]};
    assign dt_inc   = dt_reg + 3'd1;
    assign dt_need  = long_reg ? esd_pkg::DIGITS_LONG : esd_pkg::DIGITS_SHORT;

    always_comb begin
        mode_next = mode_reg;
        hv_next   = hv_reg;
        dt_next   = dt_reg;
        long_next = long_reg;
        n         = 2'd0;
        res[0]    = '0;
        res[1]    = '0;

        case (mode_reg)
            esd_pkg::MODE_ESC: begin
                mode_next = esd_pkg::MODE_NORMAL;
                n         = 2'd1;
                res[0].has = 1'b1;
                case (c)
                    esd_pkg::CH_A: res[0].ch = esd_pkg::CODE_BEL;
                    esd_pkg::CH_B: res[0].ch = esd_pkg::CODE_BS;
                    esd_pkg::CH_F: res[0].ch = esd_pkg::CODE_FF;
                    esd_pkg::CH_N: res[0].ch = esd_pkg::CODE_LF;
                    esd_pkg::CH_R: res[0].ch = esd_pkg::CODE_CR;
                    esd_pkg::CH_T: res[0].ch = esd_pkg::CODE_HT;
                    esd_pkg::CH_V: res[0].ch = esd_pkg::CODE_VT;
                    esd_pkg::CH_X, esd_pkg::CH_U: begin
                        n          = 2'd0;
                        res[0]     = '0;
                        mode_next  = esd_pkg::MODE_HEX;
                        long_next  = (c == esd_pkg::CH_U);
                        hv_next    = '0;
                        dt_next    = 3'd0;
                    end
                    default: res[0].ch = c;
                endcase
            end
            esd_pkg::MODE_HEX: begin
                if (digit[4]) begin
                    hv_next = hv_shift;
                    dt_next = dt_inc;
                    if (dt_inc >= dt_need) begin
                        if (hv_shift != '0) begin
                            res[0].ch  = esd_pkg::CHAR_W'(hv_shift);
                            res[0].has = 1'b1;
                            n          = 2'd1;
                        end
                        mode_next = esd_pkg::MODE_NORMAL;
                        hv_next   = '0;
                        dt_next   = 3'd0;
                        long_next = 1'b0;
                    end
                end else begin
                    if (dt_reg != 3'd0 && hv_reg != '0) begin
                        res[0].ch  = esd_pkg::CHAR_W'(hv_reg);
                        res[0].has = 1'b1;
                        n          = 2'd1;
                    end
                    hv_next   = '0;
                    dt_next   = 3'd0;
                    long_next = 1'b0;
                    if (c == esd_pkg::CH_BSLASH) begin
                        mode_next = esd_pkg::MODE_ESC;
                    end else begin
                        mode_next      = esd_pkg::MODE_NORMAL;
                        res[n[0]].ch   = c;
                        res[n[0]].has  = 1'b1;
                        n              = n + 2'd1;
                    end
                end
            end
            default: begin
                if (c == esd_pkg::CH_BSLASH) begin
                    mode_next = esd_pkg::MODE_ESC;
                end else begin
                    mode_next  = esd_pkg::MODE_NORMAL;
                    res[0].ch  = c;
                    res[0].has = 1'b1;
                    n          = 2'd1;
                end
            end
        endcase

        if (in_last) begin
            // A pending hex escape is flushed at the end of the string.
            if (mode_next == esd_pkg::MODE_HEX && dt_next != 3'd0 && hv_next != '0
                && n != 2'd2) begin
                res[n[0]].ch  = esd_pkg::CHAR_W'(hv_next);
                res[n[0]].has = 1'b1;
                n             = n + 2'd1;
            end
            mode_next = esd_pkg::MODE_NORMAL;
            hv_next   = '0;
            dt_next   = 3'd0;
            long_next = 1'b0;
            if (n == 2'd0) begin
                n = 2'd1;
            end
            if (n == 2'd2) begin
                res[1].last = 1'b1;
            end else begin
                res[0].last = 1'b1;
            end
        end
    end

    assign dec.count = n;
    assign dec.res0  = res[0];
    assign dec.res1  = res[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= esd_pkg::MODE_NORMAL;
            hv_reg   <= '0;
            dt_reg   <= 3'd0;
            long_reg <= 1'b0;
        end else if (fire) begin
            mode_reg <= mode_next;
            hv_reg   <= hv_next;
            dt_reg   <= dt_next;
            long_reg <= long_next;
        end
    end

endmodule

// File: rtl/esd_outq.sv
// Result register holding up to two decoded beats and presenting them one at a time.
module esd_outq (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load,
    input  esd_pkg::dec_t              dec,
    output logic                       free,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [esd_pkg::CHAR_W-1:0] m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast
);

    esd_pkg::res_t q0_reg, q0_next;
    esd_pkg::res_t q1_reg, q1_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          pop;

    assign pop  = (cnt_reg != 2'd0) && m_tready;
    assign free = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);

    always_comb begin
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        cnt_next = cnt_reg;
        if (load) begin
            q0_next  = dec.res0;
            q1_next  = dec.res1;
            cnt_next = dec.count;
        end else if (pop) begin
            q0_next  = q1_reg;
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = q0_reg.ch;
    assign m_tuser  = q0_reg.has;
    assign m_tlast  = q0_reg.last;

endmodule

// File: rtl/escape_sequence_decoder_unit.sv
// Top level of the streaming C-style escape sequence decoder.
//
// The slave channel takes one character per beat with tlast on the final
// character of each string. The master channel returns decoded characters;
// tuser is high when tdata carries a character and low for a bare end
// marker, and tlast marks the final beat of each string.
// An accepted beat sits in an input register, is decoded combinationally into a
// result register that holds up to two output beats, and its first result is
// presented from the result register. A beat that yields no result (such as a
// backslash) is absorbed without any output beat.
// Throughput is one input beat per cycle while the receiver takes every output
// beat and each beat yields at most one result; a beat that yields two results
// holds back the next beat until its second result is being taken. The result
// register is the limiting element. When the receiver stalls, the result register
// holds its beats and the input register fills, after which s_tready drops.
// Synchronous reset clears all valid flags and returns the decoder to normal mode.
module escape_sequence_decoder_unit #(
    parameter int CHAR_BITS = esd_pkg::CHAR_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // in_char
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_char
    output logic        m_tuser,   // has_char
    output logic        m_tlast
);

    logic                       in_v_reg, in_v_next;
    logic [esd_pkg::CHAR_W-1:0] in_char_reg;
    logic                       in_last_reg;
    logic                       free;
    logic                       fire;
    esd_pkg::dec_t              dec;

    assign fire      = in_v_reg && free;
    assign s_tready  = !in_v_reg || fire;
    assign in_v_next = (s_tvalid && s_tready) ? 1'b1 : (fire ? 1'b0 : in_v_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else begin
            in_v_reg <= in_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    esd_decode #(
        .CHAR_BITS(CHAR_BITS)
    ) u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .in_char (in_char_reg),
        .in_last (in_last_reg),
        .dec     (dec)
    );

    esd_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .dec      (dec),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: rtl/esd_checker.sv
// Port-level assertions for the escape sequence decoder and their binding.
module esd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // A stalled output beat holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=>
            m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled output beat changed");

    // A beat without a character only ever closes a string.
    a_bare_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("bare end marker without tlast");

    a_bare_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 16'd0)
        else $error("bare end marker with nonzero data");

    // Reset empties the result register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind escape_sequence_decoder_unit esd_checker u_esd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
